// ===== hdl/divisor_sum_range_accumulator_assert.svh =====
// assertion macros for the divisor sum range accumulator
`ifndef DIVISOR_SUM_RANGE_ACCUMULATOR_ASSERT_SVH
`define DIVISOR_SUM_RANGE_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DSRA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsra check failed");

// next-cycle implication, sampled on clk, off during reset
`define DSRA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsra check failed");

`endif

// ===== hdl/dsra_pkg.sv =====
// shared constants, types and helpers for the divisor sum range accumulator
package dsra_pkg;

	// width of the numbers after masking
	localparam int NUM_W = 20;
	// fixed field widths
	localparam int IN_W  = 20;
	localparam int OUT_W = 48;
	// arithmetic width: holds (d + r) * (r - d + 1) and every prefix total
	localparam int ACC_W = 2 * NUM_W + 1;
	// loop index width, holds up to top + 1
	localparam int D_W   = NUM_W + 1;
	// step counter of the shared unit
	localparam int CNT_W = $clog2(NUM_W);
	// width used for the saturation compare
	localparam int EXT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W + 1;

	localparam logic [OUT_W-1:0] TOTAL_MAX = {OUT_W{1'b1}};

	// shared unit operations
	typedef logic [0:0] alu_op_t;
	localparam alu_op_t ALU_DIV = 1'b0;
	localparam alu_op_t ALU_MUL = 1'b1;

	// request from the sequencer to the shared unit
	typedef struct packed {
		logic             start;
		alu_op_t          op;
		logic [NUM_W-1:0] a;      // dividend or multiplier
		logic [ACC_W-1:0] b;      // divisor or multiplicand
	} alu_req_t;

	// status and result from the shared unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [ACC_W-1:0] result;
	} alu_resp_t;

	// mask an input field to the number width
	function automatic logic [NUM_W-1:0] to_num(input logic [IN_W-1:0] v);
		return NUM_W'(v);
	endfunction

	// clamp a total to the output range
	function automatic logic [OUT_W-1:0] sat_total(input logic [ACC_W-1:0] x);
		logic [EXT_W-1:0] ext;
		begin
			ext = EXT_W'(x);
			if (ext > EXT_W'(TOTAL_MAX)) begin
				return TOTAL_MAX;
			end else begin
				return ext[OUT_W-1:0];
			end
		end
	endfunction

endpackage

// ===== hdl/dsra_range_if.sv =====
// input channel: one range per transaction
interface dsra_range_if
	import dsra_pkg::*;
;
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] range_first;
	logic [IN_W-1:0] range_last;

	modport source (output valid, output range_first, output range_last, input ready);
	modport sink (input valid, input range_first, input range_last, output ready);
endinterface

// ===== hdl/dsra_total_if.sv =====
// output channel: one divisor total per transaction
interface dsra_total_if
	import dsra_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] divisor_total;

	modport source (output valid, output divisor_total, input ready);
	modport sink (input valid, input divisor_total, output ready);
endinterface

// ===== hdl/divisor_sum_range_accumulator.sv =====
// Divisor sum range accumulator: sum of sigma(n) over first..last inclusive.
// range_in carries range_first and range_last; total_out carries divisor_total,
// one result transaction for every input transaction, saturating at 2^48 - 1.
// The total is S(last) - S(first - 1), where S(N) = sum of d * floor(N/d) is
// walked in blocks of equal floor(N/d). Each block costs two divides and two
// multiplies on one shared bit-serial unit. S(N) takes about 2 * sqrt(N)
// blocks; an empty range (first > last) skips the walk and gives zero.
// range_in.ready is high only while the sequencer is idle; one item is worked
// on at a time. The result sits in an output register, so a new range is
// taken while the previous total still waits; a stalled receiver holds the
// sequencer at its last step until the register frees.
// Reset (arst_n low, asynchronous) drops total_out.valid and returns to idle.
module divisor_sum_range_accumulator
	import dsra_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	dsra_range_if.sink          range_in,
	dsra_total_if.source        total_out
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CHK  = 3'd1;
	localparam logic [2:0] ST_DIV1 = 3'd2;
	localparam logic [2:0] ST_DIV2 = 3'd3;
	localparam logic [2:0] ST_MUL1 = 3'd4;
	localparam logic [2:0] ST_MUL2 = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]       state_q;
	logic             phase_q;
	logic             launched_q;
	logic [NUM_W-1:0] first_q;
	logic [NUM_W-1:0] top_q;
	logic [D_W-1:0]   d_q;
	logic [NUM_W-1:0] q_q;
	logic [NUM_W-1:0] r_q;
	logic [ACC_W-1:0] p_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] hi_q;
	logic             ovalid_q;
	logic [OUT_W-1:0] total_q;

	alu_req_t         alu_req;
	alu_resp_t        alu_resp;

	logic [NUM_W-1:0] in_first;
	logic [NUM_W-1:0] in_last;
	logic             in_take;
	logic             out_free;
	logic             op_state;

	assign in_first = to_num(range_in.range_first);
	assign in_last  = to_num(range_in.range_last);
	assign range_in.ready = (state_q == ST_IDLE);
	assign in_take  = range_in.valid && range_in.ready;
	assign out_free = !ovalid_q || total_out.ready;
	assign op_state = (state_q == ST_DIV1) || (state_q == ST_DIV2) ||
		(state_q == ST_MUL1) || (state_q == ST_MUL2);

	// operand selection for the shared unit
	always_comb begin
		alu_req.start = op_state && !launched_q;
		alu_req.op    = ALU_DIV;
		alu_req.a     = top_q;
		alu_req.b     = ACC_W'(d_q);
		unique case (state_q)
			ST_DIV2: begin
				alu_req.b = ACC_W'(q_q);
			end
			ST_MUL1: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = NUM_W'(D_W'(r_q) - d_q + 1'b1);
				alu_req.b  = ACC_W'(d_q) + ACC_W'(r_q);
			end
			ST_MUL2: begin
				alu_req.op = ALU_MUL;
				alu_req.a  = q_q;
				alu_req.b  = p_q;
			end
			default: begin
			end
		endcase
	end

	dsra_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.resp   (alu_resp)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= 1'b0;
			launched_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			// output register: load a finished total, free on a taken transaction
			if (state_q == ST_OUT && out_free) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && total_out.ready) begin
				ovalid_q <= 1'b0;
			end
			if (alu_req.start) begin
				launched_q <= 1'b1;
			end else if (alu_resp.done) begin
				launched_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						phase_q <= 1'b0;
						state_q <= (in_first > in_last) ? ST_OUT : ST_CHK;
					end
				end
				ST_CHK: begin
					if (d_q > D_W'(top_q)) begin
						if (!phase_q && first_q != '0) begin
							phase_q <= 1'b1;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1: begin
					if (alu_resp.done) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (alu_resp.done) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					if (alu_resp.done) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (alu_resp.done) begin
						state_q <= ST_CHK;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sequencer datapath: loop index, block values and running totals
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					first_q <= in_first;
					top_q   <= in_last;
					acc_q   <= '0;
					d_q     <= D_W'(1);
				end
			end
			ST_CHK: begin
				if (d_q > D_W'(top_q)) begin
					if (!phase_q) begin
						hi_q <= acc_q;
						if (first_q != '0) begin
							top_q <= first_q - 1'b1;
							acc_q <= '0;
							d_q   <= D_W'(1);
						end
					end else begin
						acc_q <= hi_q - acc_q;
					end
				end
			end
			ST_DIV1: begin
				if (alu_resp.done) begin
					q_q <= NUM_W'(alu_resp.result);
				end
			end
			ST_DIV2: begin
				if (alu_resp.done) begin
					r_q <= NUM_W'(alu_resp.result);
				end
			end
			ST_MUL1: begin
				if (alu_resp.done) begin
					p_q <= alu_resp.result >> 1;
				end
			end
			ST_MUL2: begin
				if (alu_resp.done) begin
					acc_q <= acc_q + alu_resp.result;
					d_q   <= D_W'(r_q) + 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					total_q <= sat_total(acc_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign total_out.valid         = ovalid_q;
	assign total_out.divisor_total = total_q;

	`include "divisor_sum_range_accumulator_assert.svh"

	// the shared unit is quiet whenever a new range may enter
	`DSRA_ASSERT_NOW(a_idle_alu_quiet, state_q == ST_IDLE, !alu_resp.busy && !launched_q)
	// a done pulse only answers an operation the sequencer launched
	`DSRA_ASSERT_NOW(a_done_launched, alu_resp.done, launched_q && op_state)
	// the loop index never reaches zero while the walk runs
	`DSRA_ASSERT_NOW(a_index_nonzero, state_q == ST_CHK, d_q != '0)
	// a result leaving the sequencer is presented the next cycle
	`DSRA_ASSERT_NEXT(a_result_shown, state_q == ST_OUT && out_free, total_out.valid)

endmodule

// ===== hdl/dsra_alu.sv =====
// shared bit-serial unit: restoring divide or shift-add multiply, one bit per cycle
module dsra_alu
	import dsra_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  alu_req_t  req,
	output alu_resp_t resp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	alu_op_t          op_q;
	logic [NUM_W-1:0] sh_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] b_q;

	logic             msb;
	logic [ACC_W-1:0] add_x;
	logic [ACC_W-1:0] add_y;
	logic             add_cin;
	logic [ACC_W:0]   add_sum;
	logic             ge;

	// one adder serves both operations
	always_comb begin
		msb = sh_q[NUM_W-1];
		if (op_q == ALU_DIV) begin
			add_x   = {acc_q[ACC_W-2:0], msb};
			add_y   = ~b_q;
			add_cin = 1'b1;
		end else begin
			add_x   = {acc_q[ACC_W-2:0], 1'b0};
			add_y   = msb ? b_q : '0;
			add_cin = 1'b0;
		end
		add_sum = {1'b0, add_x} + {1'b0, add_y} + (ACC_W + 1)'(add_cin);
		ge      = add_sum[ACC_W];
	end

	// control: step count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder or product, and the shifting operand
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			op_q  <= req.op;
			sh_q  <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (op_q == ALU_DIV) begin
				acc_q <= ge ? add_sum[ACC_W-1:0] : add_x;
				sh_q  <= {sh_q[NUM_W-2:0], ge};
			end else begin
				acc_q <= add_sum[ACC_W-1:0];
				sh_q  <= {sh_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign resp.busy   = busy_q;
	assign resp.done   = done_q;
	assign resp.result = (op_q == ALU_DIV) ? ACC_W'(sh_q) : acc_q;

endmodule
